// ----- rtl/apsp_pkg.sv -----
// Shared constants and types for the all-pairs shortest path block.
package apsp_pkg;
	localparam int MaxVertices = 16;
	localparam int VtxW = 5;
	localparam int DistW = 21;
	localparam int LenW = 20;
	localparam int WeightW = 16;
	localparam int KindW = 2;
	localparam logic [WeightW-1:0] NoEdgeMark = 16'd10000;

	typedef enum logic [KindW-1:0] {
		KIND_NONE = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_VERTEX = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CMD_IDLE = 3'd0,
		CMD_RLX_RD_IJ = 3'd1,
		CMD_RLX_RD = 3'd2,
		CMD_RLX_WR = 3'd3,
		CMD_SRCH = 3'd4,
		CMD_SUMMARY = 3'd5,
		CMD_WALK_RD = 3'd6,
		CMD_WALK_EMIT = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [VtxW-1:0] source_vertex;
		logic [VtxW-1:0] target_vertex;
		logic [LenW-1:0] path_length;
		logic [VtxW-1:0] path_vertex;
		logic last;
	} result_t;
endpackage

// ----- rtl/apsp_if.sv -----
// Valid/ready channel interfaces for edge weights, results and configuration.
interface apsp_in_if;
	logic valid;
	logic ready;
	logic [apsp_pkg::WeightW-1:0] edge_weight;
	modport source (output valid, output edge_weight, input ready);
	modport sink (input valid, input edge_weight, output ready);
endinterface

interface apsp_out_if;
	logic valid;
	logic ready;
	logic [apsp_pkg::KindW-1:0] kind;
	logic [apsp_pkg::VtxW-1:0] source_vertex;
	logic [apsp_pkg::VtxW-1:0] target_vertex;
	logic [apsp_pkg::LenW-1:0] path_length;
	logic [apsp_pkg::VtxW-1:0] path_vertex;
	logic last;
	modport source (output valid, output kind, output source_vertex, output target_vertex,
		output path_length, output path_vertex, output last, input ready);
	modport sink (input valid, input kind, input source_vertex, input target_vertex,
		input path_length, input path_vertex, input last, output ready);
endinterface

interface apsp_cfg_if;
	logic valid;
	logic ready;
	logic [apsp_pkg::VtxW-1:0] vertex_count;
	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

// ----- rtl/apsp_ctrl.sv -----
// Controller that sequences load, relaxation, search and path walk.
module apsp_ctrl #(
	parameter int MAX_V = apsp_pkg::MaxVertices,
	localparam int IW = $clog2(MAX_V),
	localparam int CW = $clog2(MAX_V) + 1
) (
	input logic clk,
	input logic arst_n,
	input logic [CW-1:0] n_i,
	input logic in_valid,
	input logic cfg_valid,
	input logic out_busy,
	input logic found,
	input logic walk_done,
	output logic in_ready,
	output logic cfg_ready,
	output logic ld_en,
	output logic [IW-1:0] a_q,
	output logic [IW-1:0] b_q,
	output logic [IW-1:0] c_q,
	output apsp_pkg::cmd_t cmd_q
);
	typedef enum logic [3:0] {
		S_LOAD, S_RLX_A, S_RLX_B, S_RLX_C, S_SRCH_A, S_SRCH_B, S_EMIT, S_WALK_A,
		S_WALK_B, S_WALK_C
	} state_t;
	state_t state_q;
	logic [IW-1:0] nm1;
	logic in_fire;
	logic cfg_fire;
	logic last_step_q;

	assign nm1 = IW'(n_i - CW'(1));
	assign cfg_ready = (state_q == S_LOAD);
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_ready = (state_q == S_LOAD) && !out_busy && !cfg_valid;
	assign in_fire = in_valid && in_ready;
	assign ld_en = in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			cmd_q <= apsp_pkg::CMD_IDLE;
			last_step_q <= 1'b0;
		end else begin
			cmd_q <= apsp_pkg::CMD_IDLE;
			last_step_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (cfg_fire) begin
						a_q <= '0;
						b_q <= '0;
					end else if (in_fire) begin
						if (b_q == nm1) begin
							b_q <= '0;
							if (a_q == nm1) begin
								a_q <= '0;
								c_q <= '0;
								state_q <= S_RLX_A;
							end else begin
								a_q <= a_q + IW'(1);
							end
						end else begin
							b_q <= b_q + IW'(1);
						end
					end
				end
				S_RLX_A: begin
					// a=k, b=i, c=j.
					cmd_q <= apsp_pkg::CMD_RLX_RD;
					state_q <= S_RLX_B;
				end
				S_RLX_B: begin
					cmd_q <= apsp_pkg::CMD_RLX_RD_IJ;
					state_q <= S_RLX_C;
				end
				S_RLX_C: begin
					cmd_q <= apsp_pkg::CMD_RLX_WR;
					state_q <= S_RLX_A;
					if (c_q == nm1) begin
						c_q <= '0;
						if (b_q == nm1) begin
							b_q <= '0;
							if (a_q == nm1) begin
								a_q <= '0;
								state_q <= S_SRCH_A;
							end else begin
								a_q <= a_q + IW'(1);
							end
						end else begin
							b_q <= b_q + IW'(1);
						end
					end else begin
						c_q <= c_q + IW'(1);
					end
				end
				S_SRCH_A: begin
					// a=i, c=j; the read is issued here and its result is compared in the datapath once registered.
					cmd_q <= apsp_pkg::CMD_SRCH;
					last_step_q <= (a_q == nm1) && (c_q == nm1);
					state_q <= S_SRCH_B;
				end
				S_SRCH_B: begin
					if (c_q == nm1) begin
						c_q <= '0;
						a_q <= a_q + IW'(1);
					end else begin
						c_q <= c_q + IW'(1);
					end
					if (last_step_q) state_q <= S_EMIT;
					else state_q <= S_SRCH_A;
				end
				S_EMIT: begin
					if (!out_busy) begin
						cmd_q <= apsp_pkg::CMD_SUMMARY;
						a_q <= '0;
						b_q <= '0;
						c_q <= '0;
						state_q <= S_WALK_A;
					end
				end
				S_WALK_A: begin
					if (!found) begin
						state_q <= S_LOAD;
					end else begin
						cmd_q <= apsp_pkg::CMD_WALK_RD;
						state_q <= S_WALK_B;
					end
				end
				S_WALK_B: begin
					state_q <= S_WALK_C;
				end
				S_WALK_C: begin
					if (!out_busy) begin
						cmd_q <= apsp_pkg::CMD_WALK_EMIT;
						state_q <= walk_done ? S_LOAD : S_WALK_A;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ----- rtl/apsp_dp.sv -----
// Datapath with the distance and next-hop memories, search registers and result register.
module apsp_dp #(
	parameter int MAX_V = apsp_pkg::MaxVertices,
	localparam int IW = $clog2(MAX_V),
	localparam int CW = $clog2(MAX_V) + 1,
	localparam int AW = 2 * $clog2(MAX_V)
) (
	input logic clk,
	input logic arst_n,
	input logic [CW-1:0] n_i,
	input logic [apsp_pkg::WeightW-1:0] weight,
	input logic ld_i,
	input logic [IW-1:0] a_i,
	input logic [IW-1:0] b_i,
	input logic [IW-1:0] c_i,
	input apsp_pkg::cmd_t cmd_i,
	input logic out_ready,
	output logic out_valid,
	output apsp_pkg::result_t out_data,
	output logic found,
	output logic walk_done
);
	logic [apsp_pkg::DistW:0] dist_mem [2**AW];
	logic [IW-1:0] hop_mem [2**AW];
	logic [apsp_pkg::DistW:0] rd_ik_q, rd_kj_q, rd_ij_q;
	logic [IW-1:0] hop_ik_q;
	logic [AW-1:0] hold_addr_q;
	logic [apsp_pkg::DistW:0] wr_dist;
	logic [apsp_pkg::DistW-1:0] sum;
	logic do_wr;
	logic [apsp_pkg::DistW-1:0] best_q;
	logic [IW-1:0] u_q, v_q, cur_q;
	logic found_q;
	logic [CW-1:0] steps_q;
	logic srch_pend_q;
	logic [IW-1:0] si_q, sj_q;
	logic [IW-1:0] nxt_q;
	logic walk_done_q;
	logic [apsp_pkg::DistW:0] ld_entry;
	logic [IW-1:0] ld_hop;

	assign found = found_q;
	assign walk_done = walk_done_q;
	assign sum = rd_ik_q[apsp_pkg::DistW-1:0] + rd_kj_q[apsp_pkg::DistW-1:0];
	assign do_wr = rd_ik_q[apsp_pkg::DistW] && rd_kj_q[apsp_pkg::DistW] &&
		(!rd_ij_q[apsp_pkg::DistW] || rd_ij_q[apsp_pkg::DistW-1:0] > sum);
	assign wr_dist = {1'b1, sum};

	always_comb begin
		if (a_i == b_i) begin
			ld_entry = {1'b1, {apsp_pkg::DistW{1'b0}}};
			ld_hop = a_i;
		end else if (weight != '0 && weight != apsp_pkg::NoEdgeMark) begin
			ld_entry = {1'b1, (apsp_pkg::DistW-apsp_pkg::WeightW)'(0), weight};
			ld_hop = b_i;
		end else begin
			ld_entry = '0;
			ld_hop = '0;
		end
	end

	// Memory ports: one write, at most two reads, all registered.
	always_ff @(posedge clk) begin
		if (ld_i) begin
			dist_mem[{a_i, b_i}] <= ld_entry;
			hop_mem[{a_i, b_i}] <= ld_hop;
		end
		case (cmd_i)
			apsp_pkg::CMD_RLX_RD: begin
				rd_ik_q <= dist_mem[{b_i, a_i}];
				hop_ik_q <= hop_mem[{b_i, a_i}];
				rd_kj_q <= dist_mem[{a_i, c_i}];
				hold_addr_q <= {b_i, c_i};
			end
			apsp_pkg::CMD_RLX_RD_IJ: begin
				rd_ij_q <= dist_mem[{b_i, c_i}];
			end
			apsp_pkg::CMD_RLX_WR: begin
				if (do_wr) begin
					dist_mem[hold_addr_q] <= wr_dist;
					hop_mem[hold_addr_q] <= hop_ik_q;
				end
			end
			apsp_pkg::CMD_SRCH: begin
				rd_ij_q <= dist_mem[{a_i, c_i}];
			end
			apsp_pkg::CMD_WALK_RD: begin
				nxt_q <= hop_mem[{cur_q, v_q}];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_data <= '0;
			found_q <= 1'b0;
			srch_pend_q <= 1'b0;
			walk_done_q <= 1'b0;
			steps_q <= '0;
			best_q <= '0;
			u_q <= '0;
			v_q <= '0;
			cur_q <= '0;
			si_q <= '0;
			sj_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			srch_pend_q <= (cmd_i == apsp_pkg::CMD_SRCH);
			if (cmd_i == apsp_pkg::CMD_SRCH) begin
				si_q <= a_i;
				sj_q <= c_i;
				if (a_i == '0 && c_i == '0) found_q <= 1'b0;
			end
			if (srch_pend_q && si_q != sj_q && rd_ij_q[apsp_pkg::DistW] &&
				(!found_q || rd_ij_q[apsp_pkg::DistW-1:0] > best_q)) begin
				found_q <= 1'b1;
				best_q <= rd_ij_q[apsp_pkg::DistW-1:0];
				u_q <= si_q;
				v_q <= sj_q;
			end
			if (cmd_i == apsp_pkg::CMD_SUMMARY) begin
				out_valid <= 1'b1;
				out_data <= '0;
				if (found_q) begin
					out_data.kind <= apsp_pkg::KIND_SUMMARY;
					out_data.source_vertex <= apsp_pkg::VtxW'(u_q) + apsp_pkg::VtxW'(1);
					out_data.target_vertex <= apsp_pkg::VtxW'(v_q) + apsp_pkg::VtxW'(1);
					out_data.path_length <= best_q[apsp_pkg::LenW-1:0];
				end else begin
					out_data.kind <= apsp_pkg::KIND_NONE;
					out_data.last <= 1'b1;
				end
				cur_q <= u_q;
				steps_q <= CW'(1);
				walk_done_q <= (u_q == v_q) || (n_i <= CW'(1));
			end
			if (cmd_i == apsp_pkg::CMD_WALK_EMIT) begin
				out_valid <= 1'b1;
				out_data <= '0;
				out_data.kind <= apsp_pkg::KIND_VERTEX;
				out_data.path_vertex <= apsp_pkg::VtxW'(cur_q) + apsp_pkg::VtxW'(1);
				out_data.last <= walk_done_q;
				if (!walk_done_q) begin
					if (CW'(nxt_q) >= n_i) cur_q <= v_q;
					else cur_q <= nxt_q;
					steps_q <= steps_q + CW'(1);
					walk_done_q <= (((CW'(nxt_q) >= n_i) ? v_q : nxt_q) == v_q) ||
						(steps_q + CW'(1) >= n_i);
				end
			end
		end
	end
endmodule

// ----- rtl/all_pairs_shortest_path_max_top.sv -----
// Top level of the all-pairs longest shortest path block.
//
// Channel  Role    Fields
// in       sink    edge_weight
// out      source  kind, source_vertex, target_vertex, path_length, path_vertex, last
// cfg      sink    vertex_count
//
// Loading takes one item per cycle unless input is held off; the last item starts
// relaxation through the distance memory, then the search and a path walk that emits
// one vertex per step. Reset sets the vertex count to 16 (clamped to MAX_V) and the
// load position to zero; memory contents are undefined until loaded. The block holds
// off input while the result register is full and not taken, configuration is offered
// or a run is in progress, and accepts configuration only in the load state.
module all_pairs_shortest_path_max_top #(
	parameter int MAX_V = apsp_pkg::MaxVertices
) (
	input logic clk,
	input logic arst_n,
	apsp_in_if.sink in_ch,
	apsp_out_if.source out_ch,
	apsp_cfg_if.sink cfg_ch
);
	localparam int IW = $clog2(MAX_V);
	localparam int CW = $clog2(MAX_V) + 1;
	logic [apsp_pkg::VtxW-1:0] vc_q;
	logic [CW-1:0] n_act;
	logic in_ready, cfg_ready, cfg_fire, ld_en, found, walk_done;
	logic [IW-1:0] a, b, c;
	apsp_pkg::cmd_t cmd;
	apsp_pkg::result_t res;

	assign cfg_ch.ready = cfg_ready;
	assign cfg_fire = cfg_ch.valid && cfg_ready;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= apsp_pkg::VtxW'(16);
		else if (cfg_fire) vc_q <= cfg_ch.vertex_count;
	end

	always_comb begin
		if (vc_q == '0) n_act = CW'(1);
		else if (32'(vc_q) > MAX_V) n_act = CW'(MAX_V);
		else n_act = CW'(vc_q);
	end

	apsp_ctrl #(.MAX_V(MAX_V)) u_ctrl (
		.clk, .arst_n, .n_i(n_act), .in_valid(in_ch.valid), .cfg_valid(cfg_ch.valid),
		.out_busy(out_ch.valid && !out_ch.ready), .found, .walk_done, .in_ready,
		.cfg_ready, .ld_en, .a_q(a), .b_q(b), .c_q(c), .cmd_q(cmd)
	);

	apsp_dp #(.MAX_V(MAX_V)) u_dp (
		.clk, .arst_n, .n_i(n_act), .weight(in_ch.edge_weight), .ld_i(ld_en), .a_i(a),
		.b_i(b), .c_i(c), .cmd_i(cmd), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.out_data(res), .found, .walk_done
	);

	assign out_ch.kind = res.kind;
	assign out_ch.source_vertex = res.source_vertex;
	assign out_ch.target_vertex = res.target_vertex;
	assign out_ch.path_length = res.path_length;
	assign out_ch.path_vertex = res.path_vertex;
	assign out_ch.last = res.last;
endmodule
